// ===== hw/rtl/fcc_pkg.sv =====
// Shared types and constants for the four-lag cross-correlation core.
`default_nettype none

package fcc_pkg;

    // Number of lags, and the y window that trails the newest sample.
    localparam int LAG_COUNT = 4;
    localparam int WIN_DEPTH = LAG_COUNT - 1;
    localparam int LAG_W     = 2;
    localparam int ACC_W     = 32;
    localparam int FIELD_W   = 16;

    localparam logic [LAG_W-1:0] LAST_LAG = LAG_W'(LAG_COUNT - 1);

    // Depth of the command queue between the front and the back.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Opcodes as they arrive on the input channel.
    localparam logic [1:0] OP_PRELOAD = 2'd0;
    localparam logic [1:0] OP_PRIME   = 2'd1;
    localparam logic [1:0] OP_STEP    = 2'd2;

    typedef enum logic [1:0] {
        KIND_PRELOAD,
        KIND_PRIME,
        KIND_STEP
    } op_kind_t;

    // One classified command, with the raw sample fields.
    typedef struct packed {
        op_kind_t                  kind;
        logic [LAG_W-1:0]          lag;
        logic signed [ACC_W-1:0]   init;
        logic [FIELD_W-1:0]        x;
        logic [FIELD_W-1:0]        y;
        logic                      fin;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } queue_head_t;

    // Snapshot of all sums handed to the report unit.
    typedef struct packed {
        logic                                valid;
        logic [LAG_COUNT-1:0][ACC_W-1:0]     sums;
    } report_load_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fcc_front.sv =====
// Front part: accepts input beats, classifies the opcode and queues commands.
`default_nettype none

module fcc_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [1:0]                   opcode,
    input  wire logic [1:0]                   lag_index,
    input  wire logic signed [31:0]           init_value,
    input  wire logic signed [15:0]           x_sample,
    input  wire logic signed [15:0]           y_sample,
    input  wire logic                         final_step,
    output fcc_pkg::queue_head_t              head,
    input  wire logic                         pop
);
    import fcc_pkg::*;

    cmd_t               q_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;
    cmd_t               cmd;
    logic               keep;
    logic               push;
    logic               do_pop;

    // Classify the beat; the unused opcode is accepted and dropped.
    always_comb
    begin
        cmd.lag  = lag_index;
        cmd.init = init_value;
        cmd.x    = x_sample;
        cmd.y    = y_sample;
        cmd.fin  = 1'b0;
        cmd.kind = KIND_PRELOAD;
        keep     = 1'b1;
        case (opcode)
            OP_PRELOAD: cmd.kind = KIND_PRELOAD;
            OP_PRIME:   cmd.kind = KIND_PRIME;
            OP_STEP:
            begin
                cmd.kind = KIND_STEP;
                cmd.fin  = final_step;
            end
            default:    keep = 1'b0;
        endcase
    end

    assign in_ready   = (count_reg != Q_CNT_W'(Q_DEPTH));
    assign push       = in_valid && in_ready && keep;
    assign do_pop     = pop && (count_reg != '0);
    assign head.valid = (count_reg != '0);
    assign head.cmd   = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd;
        end
    end

    // The fill count never passes the queue depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("command queue overfilled");

endmodule

`default_nettype wire

// ===== hw/rtl/fcc_back.sv =====
// Back part: y window, multiply stage and the four accumulators.
`default_nettype none

module fcc_back #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire fcc_pkg::queue_head_t    head,
    output logic                         pop,
    output fcc_pkg::report_load_t        load,
    input  wire logic                    can_load
);
    import fcc_pkg::*;

    localparam int PW = 2 * SAMPLE_BITS;

    logic signed [SAMPLE_BITS-1:0] win_reg [WIN_DEPTH];
    logic signed [SAMPLE_BITS-1:0] x_ext, y_ext;
    logic signed [SAMPLE_BITS-1:0] ops [LAG_COUNT];
    logic signed [PW-1:0]          prod [LAG_COUNT];

    logic                          s1_valid_reg;
    op_kind_t                      s1_kind_reg;
    logic [LAG_W-1:0]              s1_lag_reg;
    logic signed [ACC_W-1:0]       s1_init_reg;
    logic                          s1_fin_reg;
    logic signed [PW-1:0]          s1_prod_reg [LAG_COUNT];

    logic [ACC_W-1:0]              acc_reg  [LAG_COUNT];
    logic [ACC_W-1:0]              acc_next [LAG_COUNT];
    logic signed [63:0]            prod_wide [LAG_COUNT];
    logic                          s1_retire;
    logic                          take;

    // A sample is the low SAMPLE_BITS bits of its field, read as signed.
    function automatic logic signed [SAMPLE_BITS-1:0] sample_ext(input logic [FIELD_W-1:0] f);
        logic [31:0] w;
        w = {16'b0, f};
        return w[SAMPLE_BITS-1:0];
    endfunction

    assign x_ext = sample_ext(head.cmd.x);
    assign y_ext = sample_ext(head.cmd.y);

    always_comb
    begin
        for (int k = 0; k < WIN_DEPTH; k++)
        begin
            ops[k] = win_reg[k];
        end
        ops[WIN_DEPTH] = y_ext;
        for (int k = 0; k < LAG_COUNT; k++)
        begin
            prod[k] = x_ext * ops[k];
        end
    end

    // A final step waits in stage one until the report unit is free.
    assign s1_retire = s1_valid_reg && (!s1_fin_reg || can_load);
    assign take      = head.valid && (!s1_valid_reg || s1_retire);
    assign pop       = take;

    always_comb
    begin
        for (int k = 0; k < LAG_COUNT; k++)
        begin
            prod_wide[k] = 64'(s1_prod_reg[k]);
            acc_next[k]  = acc_reg[k];
        end
        if (s1_retire)
        begin
            case (s1_kind_reg)
                KIND_PRELOAD: acc_next[s1_lag_reg] = s1_init_reg;
                KIND_STEP:
                begin
                    for (int k = 0; k < LAG_COUNT; k++)
                    begin
                        acc_next[k] = acc_reg[k] + prod_wide[k][ACC_W-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        load.valid = s1_retire && s1_fin_reg;
        for (int k = 0; k < LAG_COUNT; k++)
        begin
            load.sums[k] = acc_next[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            for (int k = 0; k < WIN_DEPTH; k++)
            begin
                win_reg[k] <= '0;
            end
            for (int k = 0; k < LAG_COUNT; k++)
            begin
                acc_reg[k] <= '0;
            end
        end
        else
        begin
            if (take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_retire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (take && (head.cmd.kind inside {KIND_PRIME, KIND_STEP}))
            begin
                for (int k = 0; k + 1 < WIN_DEPTH; k++)
                begin
                    win_reg[k] <= win_reg[k + 1];
                end
                win_reg[WIN_DEPTH - 1] <= y_ext;
            end
            for (int k = 0; k < LAG_COUNT; k++)
            begin
                acc_reg[k] <= acc_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_kind_reg <= head.cmd.kind;
            s1_lag_reg  <= head.cmd.lag;
            s1_init_reg <= head.cmd.init;
            s1_fin_reg  <= head.cmd.fin;
            for (int k = 0; k < LAG_COUNT; k++)
            begin
                s1_prod_reg[k] <= prod[k];
            end
        end
    end

    // Sums are handed over only when the report unit can take them.
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load.valid |-> can_load)
        else $error("report loaded while busy");

    // A blocked final step stays in stage one.
    a_hold_final: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_fin_reg && !can_load) |=> (s1_valid_reg && s1_fin_reg))
        else $error("blocked final step left stage one");

endmodule

`default_nettype wire

// ===== hw/rtl/fcc_report.sv =====
// Report unit: holds the four sums of a run and sends them one beat per lag.
`default_nettype none

module fcc_report (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire fcc_pkg::report_load_t   load,
    output logic                         can_load,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [1:0]                   out_lag,
    output logic signed [31:0]           sum_value,
    output logic                         last_lag
);
    import fcc_pkg::*;

    logic                    busy_reg;
    logic [LAG_W-1:0]        idx_reg;
    logic signed [ACC_W-1:0] buf_reg [LAG_COUNT];
    logic                    beat;
    logic                    last_beat;

    assign beat      = busy_reg && out_ready;
    assign last_beat = beat && (idx_reg == LAST_LAG);
    assign can_load  = !busy_reg || last_beat;

    assign out_valid = busy_reg;
    assign out_lag   = idx_reg;
    assign sum_value = buf_reg[idx_reg];
    assign last_lag  = (idx_reg == LAST_LAG);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (load.valid)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (last_beat)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (beat)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load.valid)
        begin
            for (int k = 0; k < LAG_COUNT; k++)
            begin
                buf_reg[k] <= load.sums[k];
            end
        end
    end

    // An idle report unit always sits at lag zero.
    a_idle_idx: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (idx_reg == '0))
        else $error("report index moved while idle");

endmodule

`default_nettype wire

// ===== hw/rtl/four_lag_cross_correlation_core.sv =====
// Top level of the four-lag cross-correlation core.
//
// Input channel (in_valid/in_ready): one beat per command. Opcode 0 preloads
// the accumulator named by lag_index with init_value, opcode 1 shifts
// y_sample into the three-entry y window, opcode 2 takes x_sample and the
// newest y sample and does one multiply-accumulate per lag. Opcode 3 is
// accepted and ignored.
// Output channel (out_valid/out_ready): a step with final_step set yields four
// beats, lags 0 to 3 in order, with last_lag high on the fourth.
// Throughput: one input beat per cycle while the command queue has room; the
// four multiplies of a step run in parallel in the back part's multiply stage.
// A final step holds the back part until the last beat of the previous report
// is taken, so runs of short blocks are bound by the four output beats per
// report. Path: a final step's beat passes the queue, then the multiply stage,
// then accumulate and report load, before its first result appears.
// Reset clears the window, the accumulators, the queue and the report unit.
// When the receiver stalls, the report waits, later steps keep accumulating,
// and input is refused only once the command queue fills up.
`default_nettype none

module four_lag_cross_correlation_core #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [1:0]          opcode,
    input  wire logic [1:0]          lag_index,
    input  wire logic signed [31:0]  init_value,
    input  wire logic signed [15:0]  x_sample,
    input  wire logic signed [15:0]  y_sample,
    input  wire logic                final_step,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [1:0]               out_lag,
    output logic signed [31:0]       sum_value,
    output logic                     last_lag
);
    import fcc_pkg::*;

    queue_head_t  head;
    logic         pop;
    report_load_t load;
    logic         can_load;

    // Front part: accepts beats, drops the unused opcode, queues the rest.
    fcc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .lag_index  (lag_index),
        .init_value (init_value),
        .x_sample   (x_sample),
        .y_sample   (y_sample),
        .final_step (final_step),
        .head       (head),
        .pop        (pop)
    );

    // Back part: window update and products in one stage, then accumulate.
    fcc_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .pop      (pop),
        .load     (load),
        .can_load (can_load)
    );

    // Report unit: a private copy of the sums, so accumulation goes on
    // while the receiver drains the previous report.
    fcc_report u_report (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_lag   (out_lag),
        .sum_value (sum_value),
        .last_lag  (last_lag)
    );

endmodule

`default_nettype wire

// ===== tb/four_lag_cross_correlation_core_test.sv =====
// Self-checking testbench for the four-lag cross-correlation core.
`timescale 1ns / 1ps

module four_lag_cross_correlation_core_test;
    import fcc_pkg::*;

    // Opcode 3 is not defined by the core; it must be swallowed without effect.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int TOTAL_ITEMS      = 330;
    localparam int QUIET_TAIL       = 60;    // final stretch with no idling on either side
    localparam int LONG_HOLD_CYCLES = 64;    // receiver hold-off in the pressure test
    localparam int WATCHDOG_LIMIT   = 1000;  // cycles with no beat on either channel
    localparam int DRAIN_CYCLES     = 12;    // settling time after the last expected sum, with slack
    localparam int MAX_PRINTED      = 200;

    localparam logic [15:0] SAMPLE_MIN = 16'h8000;
    localparam logic [15:0] SAMPLE_MAX = 16'h7FFF;

    // One result beat: the sum for one lag and the end-of-report marker.
    typedef struct packed {
        logic [LAG_W-1:0] lag;
        logic [ACC_W-1:0] sum;
        logic             last;
    } sum_beat_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [1:0]          opcode = OP_PRELOAD;
    logic [1:0]          lag_index = '0;
    logic signed [31:0]  init_value = '0;
    logic signed [15:0]  x_sample = '0;
    logic signed [15:0]  y_sample = '0;
    logic                final_step = 1'b0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [1:0]          out_lag;
    logic signed [31:0]  sum_value;
    logic                last_lag;

    // Predicted state of the core: the trailing y window and the four sums.
    logic signed [FIELD_W-1:0] window_model [WIN_DEPTH] = '{default: '0};
    logic [ACC_W-1:0]          sums_model [LAG_COUNT]   = '{default: '0};

    sum_beat_t expected_sums[$];

    int  error_count = 0;
    int  sent_count = 0;
    int  stalled_cycles = 0;
    int  stall_left = 0;
    bit  tx_idle_on = 1'b1;
    bit  rx_idle_on = 1'b1;
    bit  long_hold_pending = 1'b0;

    four_lag_cross_correlation_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .lag_index  (lag_index),
        .init_value (init_value),
        .x_sample   (x_sample),
        .y_sample   (y_sample),
        .final_step (final_step),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_lag    (out_lag),
        .sum_value  (sum_value),
        .last_lag   (last_lag)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Every mismatch is counted; printing stops after a while so a badly
    // broken core cannot flood the log.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("%0t: %s mismatch, got %0h, expected %0h", $time, what, got, want);
    endtask

    // The window moves toward the oldest entry and the new y sample enters last.
    function automatic void shift_window(input logic signed [FIELD_W-1:0] y);
        for (int k = 0; k + 1 < WIN_DEPTH; k++)
            window_model[k] = window_model[k + 1];
        window_model[WIN_DEPTH-1] = y;
    endfunction

    // Applies one accepted beat to the predicted state. A final step queues
    // four sums, lag 0 first; nothing else produces output.
    function automatic void correlate_item(input logic [1:0] op, input logic [1:0] lag,
                                           input logic [31:0] init,
                                           input logic signed [FIELD_W-1:0] x,
                                           input logic signed [FIELD_W-1:0] y,
                                           input logic fin);
        logic signed [ACC_W-1:0] product;
        sum_beat_t               beat;
        case (op)
            OP_PRELOAD: sums_model[lag] = init;
            OP_PRIME:   shift_window(y);
            OP_STEP:
            begin
                // A 16 by 16 signed product always fits in 32 bits; only the
                // sums wrap.
                for (int k = 0; k < WIN_DEPTH; k++)
                begin
                    product = x * window_model[k];
                    sums_model[k] = sums_model[k] + product;
                end
                product = x * y;
                sums_model[LAG_COUNT-1] = sums_model[LAG_COUNT-1] + product;
                shift_window(y);
                if (fin)
                begin
                    for (int k = 0; k < LAG_COUNT; k++)
                    begin
                        beat.lag  = LAG_W'(k);
                        beat.sum  = sums_model[k];
                        beat.last = (beat.lag == LAST_LAG);
                        expected_sums.push_back(beat);
                    end
                end
            end
            default: ;  // the unused opcode leaves everything as it was
        endcase
    endfunction

    // Compares one accepted result beat with the oldest prediction.
    task automatic check_result();
        sum_beat_t want;
        if (expected_sums.size() == 0)
        begin
            report_mismatch("unexpected result beat", sum_value, '0);
            return;
        end
        want = expected_sums.pop_front();
        if (out_lag !== want.lag)
            report_mismatch("out_lag", 32'(out_lag), 32'(want.lag));
        if (sum_value !== want.sum)
            report_mismatch($sformatf("sum_value for lag %0d", want.lag), sum_value, want.sum);
        if (last_lag !== want.last)
            report_mismatch("last_lag", 32'(last_lag), 32'(want.last));
    endtask

    // Both channels are observed at the rising edge, before this edge's
    // nonblocking updates land, so the values seen are the ones the core took.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                correlate_item(opcode, lag_index, init_value, x_sample, y_sample, final_step);
            if (out_valid && out_ready)
                check_result();
        end
    end

    // Receiver: short random stalls, and on request one long hold-off so that
    // the core backs up into its input.
    always @(posedge clk)
    begin
        if (long_hold_pending)
        begin
            long_hold_pending = 1'b0;
            stall_left = LONG_HOLD_CYCLES;
        end
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else if (rx_idle_on && $urandom_range(0, 3) == 0)
        begin
            out_ready <= 1'b0;
            stall_left = $urandom_range(0, 2);
        end
        else
            out_ready <= 1'b1;
    end

    // The run is stopped if neither channel moves a beat for too long.
    always @(posedge clk)
    begin
        if (rst_n && !((in_valid && in_ready) || (out_valid && out_ready)))
        begin
            stalled_cycles++;
            if (stalled_cycles >= WATCHDOG_LIMIT)
            begin
                $display("four_lag_cross_correlation_core verification failed");
                $finish;
            end
        end
        else
            stalled_cycles = 0;
    end

    // Offers one beat and returns at the edge where it is taken. Valid is left
    // high so that back-to-back beats need only one assignment per edge; an
    // idle burst, if any, is the only place valid drops.
    task automatic send_beat(input logic [1:0] op, input logic [1:0] lag,
                             input logic [31:0] init, input logic [15:0] x,
                             input logic [15:0] y, input logic fin);
        int gap;
        gap = (tx_idle_on && $urandom_range(0, 3) == 0) ? int'($urandom_range(1, 3)) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        lag_index  <= lag;
        init_value <= init;
        x_sample   <= x;
        y_sample   <= y;
        final_step <= fin;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent_count++;
    endtask

    // Samples lean toward the two extremes, where products are largest.
    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return SAMPLE_MIN;
            1:       return SAMPLE_MAX;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_init();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return '0;
            default: return $urandom;
        endcase
    endfunction

    // Fields that an opcode does not use carry random values throughout, so
    // any dependence on them shows up as a wrong sum.
    task automatic send_preload(input logic [1:0] lag, input logic [31:0] init);
        send_beat(OP_PRELOAD, lag, init, 16'($urandom), 16'($urandom), 1'($urandom));
    endtask

    task automatic send_prime(input logic [15:0] y);
        send_beat(OP_PRIME, 2'($urandom), $urandom, 16'($urandom), y, 1'($urandom));
    endtask

    task automatic send_step(input logic [15:0] x, input logic [15:0] y, input logic fin);
        send_beat(OP_STEP, 2'($urandom), $urandom, x, y, fin);
    endtask

    // Directed beats: the window and sums as reset left them, every opcode,
    // extreme samples and preload values, wrap-around of a sum, the final flag
    // where it means nothing, and sums carried over past a report.
    task automatic test_directed();
        // Straight out of reset the window and sums are all zero.
        send_step(16'd1000, 16'hFFFB, 1'b1);
        send_preload(2'd0, 32'h7FFF_FFFF);
        send_preload(2'd1, 32'h8000_0000);
        send_preload(2'd2, 32'h0000_0000);
        send_preload(2'd3, 32'hFFFF_FFFF);
        send_beat(OP_PRELOAD, 2'd2, 32'h1234_5678, SAMPLE_MIN, SAMPLE_MAX, 1'b1);
        send_beat(OP_PRIME, 2'd3, 32'hFFFF_FFFF, SAMPLE_MAX, SAMPLE_MIN, 1'b1);
        send_prime(SAMPLE_MAX);
        send_prime(SAMPLE_MIN);
        send_beat(OP_UNUSED, 2'd1, 32'hA5A5_5A5A, SAMPLE_MAX, SAMPLE_MAX, 1'b1);
        // The most negative square, then the largest positive one, pushes
        // lag 0 past the top of the signed range.
        send_step(SAMPLE_MIN, SAMPLE_MIN, 1'b0);
        send_step(SAMPLE_MAX, SAMPLE_MAX, 1'b1);
        // No preload: the next report builds on the sums just reported.
        send_step(16'd0, SAMPLE_MIN, 1'b0);
        send_step(SAMPLE_MIN, SAMPLE_MAX, 1'b1);
        send_beat(OP_UNUSED, 2'd0, 32'h0000_0000, 16'h0000, 16'h0000, 1'b0);
        send_step(16'hFFFF, 16'h0001, 1'b1);
    endtask

    // The receiver holds off while final steps keep coming, so the core's
    // report path and command queue fill and input must be refused.
    task automatic test_backpressure();
        long_hold_pending = 1'b1;
        for (int n = 0; n < 4; n++)
            send_preload(2'(n), pick_init());
        for (int n = 0; n < 6; n++)
            send_step(pick_sample(), pick_sample(), 1'b1);
    endtask

    // Mostly well-formed blocks with random content: preload, prime, steps,
    // final step. Some blocks skip the preload or prime short, and stray beats
    // with any opcode and random fields fall between blocks.
    task automatic test_random_blocks();
        int steps;
        int primes;
        while (sent_count < TOTAL_ITEMS)
        begin
            if (sent_count >= TOTAL_ITEMS - QUIET_TAIL)
            begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            if ($urandom_range(0, 5) == 0)
            begin
                repeat ($urandom_range(1, 3))
                    send_beat(2'($urandom), 2'($urandom), $urandom, 16'($urandom),
                              16'($urandom), 1'($urandom));
            end
            if ($urandom_range(0, 4) != 0)
            begin
                for (int n = 0; n < LAG_COUNT; n++)
                    send_preload(2'(n), pick_init());
            end
            primes = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : WIN_DEPTH;
            repeat (primes)
                send_prime(pick_sample());
            steps = $urandom_range(1, 6);
            for (int n = 1; n <= steps; n++)
                send_step(pick_sample(), pick_sample(), n == steps);
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_backpressure();
        test_random_blocks();

        in_valid <= 1'b0;
        @(posedge clk);
        // The watchdog ends the run if the remaining sums never arrive.
        while (expected_sums.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("four_lag_cross_correlation_core verification clean");
        else
            $display("four_lag_cross_correlation_core verification failed");
        $finish;
    end

endmodule
